/* hw/rtl/cpc_pkg.sv */
// Cruise PI controller package: payload, configuration and state types,
// register indexes and reset values. No dependencies.
package cpc_pkg;

  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] REG_GAIN_PROP    = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_INTEG   = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_ENGAGE_MIN   = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_GAS_THROTTLE = 8'd3;

  localparam logic [3:0] GAIN_PROP_RST    = 4'd5;
  localparam logic [3:0] GAIN_INTEG_RST   = 4'd1;
  localparam logic [7:0] ENGAGE_MIN_RST   = 8'd20;
  localparam logic [7:0] GAS_THROTTLE_RST = 8'd60;

  typedef struct packed {
    logic        [3:0]  gain_prop;
    logic        [3:0]  gain_integ;
    logic        [7:0]  engage_min_speed;
    logic        [7:0]  gas_throttle;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] speed_now;
    logic               gas_pressed;
    logic               top_gear_on;
    logic               cruise_pressed;
  } item_t;

  typedef struct packed {
    logic        [7:0]  throttle_cmd;
    logic               regulating;
    logic signed [15:0] target_shown;
    logic               request_latched;
  } result_t;

  typedef struct packed {
    logic               request_flag;
    logic               capture_pending;
    logic signed [15:0] target_speed;
    logic signed [15:0] error_sum;
    logic        [7:0]  throttle_hold;
    logic               indicator_flag;
  } ctrl_state_t;

endpackage

/* hw/rtl/cpc_if.sv */
// Handshake channels of the cruise PI controller: input item, result and
// configuration write. Depends on cpc_pkg.
interface cpc_item_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_now;
  logic               gas_pressed;
  logic               top_gear_on;
  logic               cruise_pressed;

  modport source (output valid, speed_now, gas_pressed, top_gear_on, cruise_pressed,
                  input ready);
  modport sink   (input valid, speed_now, gas_pressed, top_gear_on, cruise_pressed,
                  output ready);
endinterface

interface cpc_result_if;
  logic               valid;
  logic               ready;
  logic        [7:0]  throttle_cmd;
  logic               regulating;
  logic signed [15:0] target_shown;
  logic               request_latched;

  modport source (output valid, throttle_cmd, regulating, target_shown, request_latched,
                  input ready);
  modport sink   (input valid, throttle_cmd, regulating, target_shown, request_latched,
                  output ready);
endinterface

interface cpc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cpc_pkg::CfgIdxW-1:0]    index;
  logic [7:0]                     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/cpc_pi_step.sv */
// One control tick: request latch, gas override, target capture and PI
// update with saturation. Purely combinational. Depends on cpc_pkg.
module cpc_pi_step (
  input  cpc_pkg::cfg_t        cfg_i,
  input  cpc_pkg::ctrl_state_t state_i,
  input  cpc_pkg::item_t       item_i,
  output cpc_pkg::ctrl_state_t state_o,
  output cpc_pkg::result_t     result_o
);
  import cpc_pkg::*;

  logic               req;
  logic               engage;
  logic signed [16:0] speed_x;
  logic signed [16:0] min_x;
  logic signed [15:0] tgt;
  logic signed [16:0] err;
  logic signed [17:0] sum_wide;
  logic signed [15:0] sum_sat;
  logic signed [4:0]  gp_s;
  logic signed [4:0]  gi_s;
  logic signed [21:0] prod_p;
  logic signed [20:0] prod_i;
  logic signed [22:0] drive;
  logic        [7:0]  drive_clamp;

  assign req     = state_i.request_flag | item_i.cruise_pressed;
  assign speed_x = {item_i.speed_now[15], item_i.speed_now};
  assign min_x   = {9'b0, cfg_i.engage_min_speed};
  assign engage  = (speed_x >= min_x) && item_i.top_gear_on;

  assign tgt      = state_i.capture_pending ? item_i.speed_now : state_i.target_speed;
  assign err      = {tgt[15], tgt} - speed_x;
  assign sum_wide = {{2{state_i.error_sum[15]}}, state_i.error_sum} + {err[16], err};

  always_comb begin
    if (sum_wide[17:15] == 3'b000 || sum_wide[17:15] == 3'b111) begin
      sum_sat = sum_wide[15:0];
    end else if (sum_wide[17]) begin
      sum_sat = 16'sh8000;
    end else begin
      sum_sat = 16'sh7fff;
    end
  end

  assign gp_s   = {1'b0, cfg_i.gain_prop};
  assign gi_s   = {1'b0, cfg_i.gain_integ};
  assign prod_p = gp_s * err;
  assign prod_i = gi_s * sum_sat;
  assign drive  = {prod_p[21], prod_p} + {{2{prod_i[20]}}, prod_i};

  always_comb begin
    if (drive[22]) begin
      drive_clamp = 8'd0;
    end else if (|drive[21:8]) begin
      drive_clamp = 8'hff;
    end else begin
      drive_clamp = drive[7:0];
    end
  end

  always_comb begin
    state_o = state_i;
    if (item_i.gas_pressed) begin
      state_o.throttle_hold = cfg_i.gas_throttle;
      state_o.request_flag  = 1'b0;
    end else if (req) begin
      if (engage) begin
        state_o.request_flag    = 1'b1;
        state_o.capture_pending = 1'b0;
        state_o.target_speed    = tgt;
        state_o.indicator_flag  = 1'b1;
        state_o.error_sum       = sum_sat;
        state_o.throttle_hold   = drive_clamp;
      end else begin
        state_o.request_flag = 1'b0;
        state_o.target_speed = '0;
      end
    end else begin
      state_o.request_flag    = 1'b0;
      state_o.indicator_flag  = 1'b0;
      state_o.capture_pending = 1'b1;
      state_o.throttle_hold   = '0;
      state_o.target_speed    = '0;
    end
  end

  assign result_o.throttle_cmd    = state_o.throttle_hold;
  assign result_o.regulating      = state_o.indicator_flag;
  assign result_o.target_shown    = state_o.target_speed;
  assign result_o.request_latched = state_o.request_flag;

endmodule

/* hw/rtl/cruise_pi_controller_core.sv */
// Cruise PI controller top level: input register, control state, result
// register and configuration registers. Depends on cpc_pkg, cpc_if, cpc_pi_step.
//
//   channel | dir | beat
//   in_i    | in  | speed_now, gas_pressed, top_gear_on, cruise_pressed
//   out_o   | out | throttle_cmd, regulating, target_shown, request_latched
//   cfg_i   | in  | index, data (always ready)
//
// A beat is held in the input register, then the control logic updates the
// state and loads the result register: one beat per cycle while the output
// is not stalled, result valid once loaded. A stalled result holds the input
// register; a new beat is taken whenever the input register empties that
// cycle. Reset empties both registers, resets the state and loads the
// default gains and limits.
module cruise_pi_controller_core (
  input logic          clk_i,
  input logic          rst_ni,
  cpc_item_if.sink     in_i,
  cpc_result_if.source out_o,
  cpc_cfg_if.sink      cfg_i
);
  import cpc_pkg::*;

  cfg_t        cfg_q;
  ctrl_state_t state_q;
  ctrl_state_t state_d;
  item_t       item_q;
  logic        item_vld_q;
  result_t     res_q;
  result_t     res_d;
  logic        res_vld_q;
  logic        res_free;
  logic        advance;

  assign res_free   = !res_vld_q || out_o.ready;
  assign advance    = item_vld_q && res_free;
  assign in_i.ready = !item_vld_q || advance;
  assign cfg_i.ready = 1'b1;

  cpc_pi_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_prop        <= GAIN_PROP_RST;
      cfg_q.gain_integ       <= GAIN_INTEG_RST;
      cfg_q.engage_min_speed <= ENGAGE_MIN_RST;
      cfg_q.gas_throttle     <= GAS_THROTTLE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_GAIN_PROP:    cfg_q.gain_prop        <= cfg_i.data[3:0];
        REG_GAIN_INTEG:   cfg_q.gain_integ       <= cfg_i.data[3:0];
        REG_ENGAGE_MIN:   cfg_q.engage_min_speed <= cfg_i.data;
        REG_GAS_THROTTLE: cfg_q.gas_throttle     <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.request_flag    <= 1'b0;
      state_q.capture_pending <= 1'b1;
      state_q.target_speed    <= '0;
      state_q.error_sum       <= '0;
      state_q.throttle_hold   <= '0;
      state_q.indicator_flag  <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_i.ready) begin
        item_vld_q <= in_i.valid;
      end
      if (res_free) begin
        res_vld_q <= advance;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.speed_now      <= in_i.speed_now;
      item_q.gas_pressed    <= in_i.gas_pressed;
      item_q.top_gear_on    <= in_i.top_gear_on;
      item_q.cruise_pressed <= in_i.cruise_pressed;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = res_vld_q;
  assign out_o.throttle_cmd    = res_q.throttle_cmd;
  assign out_o.regulating      = res_q.regulating;
  assign out_o.target_shown    = res_q.target_shown;
  assign out_o.request_latched = res_q.request_latched;

endmodule
